// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_WIDTH = 5;
   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 5'd16;
   localparam logic signed [31:0] MISS_VALUE = -32'sd1;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_SET = 1'b1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] store_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              rsp_stall,
   input  logic              out_full,
   output lkvc_pkg::cmd_type cmd
);

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = lkvc_pkg::ST_RUN;
            end
         end
         lkvc_pkg::ST_RUN: begin
            if (!out_full || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = lkvc_pkg::ST_IDLE;
            end
         end
         default: state_in = lkvc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != lkvc_pkg::ST_IDLE);

endmodule

// ===== rtl/lkvc_datapath.sv =====
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lkvc_pkg::cmd_type                 cmd,
   input  lkvc_pkg::req_type                 req_data,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]    capacity,
   input  logic                              rsp_stall,
   output logic                              out_full,
   output lkvc_pkg::rsp_type                 rsp_data,
   output logic [$clog2(ENTRIES+1)-1:0]      occupancy,
   output logic [ENTRIES-1:0]                valid
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int CW = 8;
   localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
   localparam logic [IW-1:0] RANK_TOP = IW'(ENTRIES - 1);

   lkvc_pkg::req_type req_ff;
   logic [31:0]       key_ff [ENTRIES];
   logic [31:0]       value_ff [ENTRIES];
   logic [IW-1:0]     rank_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [OW-1:0]     occ_ff;
   logic              out_full_ff;
   lkvc_pkg::rsp_type rsp_ff;

   logic              found;
   logic [IW-1:0]     hit_slot;
   logic [IW-1:0]     lru_slot;
   logic [IW-1:0]     free_slot;
   logic [IW-1:0]     ins_slot;
   logic [CW-1:0]     cap_eff;
   logic              do_evict;
   logic              is_set;
   lkvc_pkg::rsp_type rsp_in;

   always_comb begin
      found     = 1'b0;
      hit_slot  = '0;
      lru_slot  = '0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.lookup_key) begin
            found    = 1'b1;
            hit_slot = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_slot = IW'(i);
         end
         if (valid_ff[i] && {1'b0, rank_ff[i]} == (IW+1)'(occ_ff - OW'(1))) begin
            lru_slot = IW'(i);
         end
      end
   end

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CW'(1);
      end else if (CW'(capacity) > ENT_C) begin
         cap_eff = ENT_C;
      end else begin
         cap_eff = CW'(capacity);
      end
      is_set   = (req_ff.mode == lkvc_pkg::MODE_SET);
      do_evict = (CW'(occ_ff) >= cap_eff) && (occ_ff != '0);
      ins_slot = do_evict ? lru_slot : free_slot;
      rsp_in.hit        = found;
      rsp_in.read_value = (found && !is_set) ? $signed(value_ff[hit_slot])
                                             : lkvc_pkg::MISS_VALUE;
      rsp_in.evicted    = !found && is_set && do_evict;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < ENTRIES; i++) begin
            if (found) begin
               if (IW'(i) == hit_slot) begin
                  rank_ff[i] <= '0;
                  if (is_set) begin
                     value_ff[i] <= req_ff.store_value;
                  end
               end else if (valid_ff[i] && rank_ff[i] < rank_ff[hit_slot]) begin
                  rank_ff[i] <= rank_ff[i] + IW'(1);
               end
            end else if (is_set) begin
               if (IW'(i) == ins_slot) begin
                  key_ff[i]   <= req_ff.lookup_key;
                  value_ff[i] <= req_ff.store_value;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i] && rank_ff[i] < RANK_TOP) begin
                  rank_ff[i] <= rank_ff[i] + IW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         occ_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            out_full_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_full_ff <= 1'b0;
         end
         if (cmd.commit && !found && is_set) begin
            valid_ff[ins_slot] <= 1'b1;
            if (!do_evict) begin
               occ_ff <= occ_ff + OW'(1);
            end
         end
      end
   end

   assign out_full  = out_full_ff;
   assign rsp_data  = rsp_ff;
   assign occupancy = occ_ff;
   assign valid     = valid_ff;

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Channel   Direction  Ports                           Handshake
// req       in         req_valid req_stall req_data    valid & !stall
// rsp       out        rsp_valid rsp_stall rsp_data    valid & !stall
// csr       in         csr_valid csr_ready csr_data    valid & ready
//
// Each transaction takes two steps: capture, then parallel key
// compare and rank update across all entries.
// The next request is taken while a result waits in the output register.
// Reset empties the cache and sets capacity to 16.
// A held rsp_stall holds the next commit while a result waits; req_stall is high while busy.
module lru_key_value_cache_top #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lkvc_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lkvc_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0] csr_data
);

   lkvc_pkg::cmd_type                 cmd;
   logic                              out_full;
   logic [lkvc_pkg::CAP_WIDTH-1:0]    capacity_ff;
   logic [$clog2(ENTRIES+1)-1:0]      occupancy;
   logic [ENTRIES-1:0]                valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_full;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .out_full  (out_full),
      .cmd       (cmd)
   );

   lkvc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .rsp_stall (rsp_stall),
      .out_full  (out_full),
      .rsp_data  (rsp_data),
      .occupancy (occupancy),
      .valid     (valid)
   );

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid) == int'(occupancy))
      else $error("occupancy out of step with valid entries");

   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      int'(occupancy) <= ENTRIES)
      else $error("occupancy above entry count");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   a_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without result");

endmodule

// ===== tb/lru_key_value_cache_checker.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_checker #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  lkvc_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  lkvc_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             hit_count,
   output int                             evict_count
);

   logic [31:0] slot_key [ENTRIES];
   logic [31:0] slot_val [ENTRIES];
   logic        slot_live [ENTRIES];
   int unsigned slot_age [ENTRIES];
   int unsigned fill;
   logic [lkvc_pkg::CAP_WIDTH-1:0] cap_reg;
   lkvc_pkg::rsp_type lookup_q [$];

   function automatic lkvc_pkg::rsp_type cache_access(lkvc_pkg::req_type r);
      lkvc_pkg::rsp_type res;
      int found;
      int slot;
      int old_age;
      int cap;
      int best;
      bit have;
      res.hit = 1'b0;
      res.read_value = lkvc_pkg::MISS_VALUE;
      res.evicted = 1'b0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_live[i] && slot_key[i] == r.lookup_key) found = i;
      if (found >= 0) begin
         res.hit = 1'b1;
         if (r.mode == lkvc_pkg::MODE_GET) res.read_value = slot_val[found];
         else slot_val[found] = r.store_value;
         old_age = slot_age[found];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != found && slot_age[i] < old_age) slot_age[i]++;
         slot_age[found] = 0;
      end else if (r.mode == lkvc_pkg::MODE_SET) begin
         cap = cap_reg;
         if (cap < 1) cap = 1;
         if (cap > ENTRIES) cap = ENTRIES;
         have = 0;
         slot = 0;
         best = 0;
         if (fill >= cap) begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot_live[i] && (!have || slot_age[i] > best)) begin
                  best = slot_age[i];
                  slot = i;
                  have = 1;
               end
            if (have) begin
               res.evicted = 1'b1;
               slot_live[slot] = 1'b0;
               if (fill > 0) fill--;
            end
         end
         if (!have)
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!slot_live[i]) begin
                  slot = i;
                  have = 1;
               end
         if (have) begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot_live[i] && slot_age[i] < ENTRIES - 1) slot_age[i]++;
            slot_key[slot] = r.lookup_key;
            slot_val[slot] = r.store_value;
            slot_live[slot] = 1'b1;
            slot_age[slot] = 0;
            fill++;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      lkvc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_live[i] = 1'b0;
            slot_age[i] = 0;
         end
         fill = 0;
         cap_reg = lkvc_pkg::CAPACITY_RESET;
         lookup_q.delete();
         fail_count = 0;
         hit_count = 0;
         evict_count = 0;
      end else begin
         if (csr_valid && csr_ready) cap_reg = csr_data;
         if (req_valid && !req_stall) lookup_q.push_back(cache_access(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (lookup_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction hit=%0b value=%0d evicted=%0b",
                        $time, rsp_data.hit, rsp_data.read_value, rsp_data.evicted);
            end else begin
               want = lookup_q.pop_front();
               if (want.hit) hit_count++;
               if (want.evicted) evict_count++;
               if (rsp_data.hit !== want.hit) begin
                  fail_count++;
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_data.hit);
               end
               if (rsp_data.read_value !== want.read_value) begin
                  fail_count++;
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           want.read_value, rsp_data.read_value);
               end
               if (rsp_data.evicted !== want.evicted) begin
                  fail_count++;
                  $display("%0t: evicted expected %0b actual %0b", $time,
                           want.evicted, rsp_data.evicted);
               end
            end
         end
      end
      pending_count = lookup_q.size();
   end
endmodule

// ===== tb/lru_key_value_cache_top_tb.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;

   localparam int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   lkvc_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b1;
   lkvc_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [lkvc_pkg::CAP_WIDTH-1:0] csr_data = '0;
   int                             fail_count, pending_count, hit_count, evict_count;
   int                             cycle_count = 0;
   bit                             calm = 1'b0;
   int                             lookup_total = 0;
   logic [31:0]                    key_pool [8];

   always #1 clock = ~clock;

   lru_key_value_cache_top #(.ENTRIES(ENTRIES)) i_dut (.*);

   lru_key_value_cache_checker #(.ENTRIES(ENTRIES)) i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at cycle limit");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock)
      if (!reset) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 14);

   task automatic send_lookup(logic mode, logic [31:0] key, logic [31:0] val);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 14) @(negedge clock);
      req_valid <= 1'b1;
      req_data <= '{mode: mode, lookup_key: key, store_value: val};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lookup_total++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_capacity(logic [lkvc_pkg::CAP_WIDTH-1:0] cap);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(9))
         0: return $urandom();
         1: return {1'($urandom_range(1)), 31'h0} | 32'($urandom_range(3));
         default: return key_pool[$urandom_range(7)];
      endcase
   endfunction

   initial begin
      logic [lkvc_pkg::CAP_WIDTH-1:0] caps [6] = '{5'd1, 5'd4, 5'd16, 5'd0, 5'd31, 5'd7};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, get/set, hit/miss, overwrite, eviction, capacity changes
      send_lookup(lkvc_pkg::MODE_GET, 32'h0, 32'h0);
      send_lookup(lkvc_pkg::MODE_SET, 32'h0, 32'hFFFF_FFFF);
      send_lookup(lkvc_pkg::MODE_GET, 32'h0, 32'h1234_5678);
      send_lookup(lkvc_pkg::MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_lookup(lkvc_pkg::MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_lookup(lkvc_pkg::MODE_SET, 32'hFFFF_FFFF, 32'h0);
      send_lookup(lkvc_pkg::MODE_SET, 32'h0, 32'hAAAA_5555);
      send_lookup(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'h0);
      send_lookup(lkvc_pkg::MODE_GET, 32'h0, 32'h0);
      send_lookup(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
      set_capacity(5'd2);
      send_lookup(lkvc_pkg::MODE_SET, 32'h5555_AAAA, 32'h1);
      send_lookup(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0);
      send_lookup(lkvc_pkg::MODE_SET, 32'h1, 32'h2);
      send_lookup(lkvc_pkg::MODE_GET, 32'h1, 32'h0);
      set_capacity(5'd0);
      send_lookup(lkvc_pkg::MODE_SET, 32'h2, 32'h3);
      send_lookup(lkvc_pkg::MODE_GET, 32'h2, 32'h0);
      set_capacity(5'd31);
      for (int i = 0; i < 8; i++) send_lookup(lkvc_pkg::MODE_SET, 32'h100 + i, ~i);

      for (int phase = 0; phase < 6; phase++) begin
         set_capacity(caps[phase]);
         for (int i = 0; i < 8; i++)
            key_pool[i] = (phase % 2) ? {1'($urandom_range(1)), 27'h0, 4'($urandom_range(15))}
                                      : $urandom();
         calm = (phase == 2);
         for (int n = 0; n < 130; n++)
            send_lookup(1'($urandom_range(1)), pick_key(), $urandom());
         calm = 1'b0;
         if (phase == 3) while (pending_count != 0) @(negedge clock);
      end

      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("%0d transactions sent, %0d hits, %0d evictions, six capacity phases",
               lookup_total, hit_count, evict_count);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
